FILE: rtl/hwpc_pkg.sv
// Shared types, constants and register codes of the heartbeat watchdog power cycler.
package hwpc_pkg;

   // Default width of the elapsed tick counter.
   localparam int TIMER_WIDTH_DEFAULT = 16;

   localparam int RUN_WIDTH   = 8;
   localparam int PHASE_WIDTH = 7;
   localparam int TICKS_WIDTH = 16;
   localparam int EDGES_WIDTH = 8;
   localparam int CSR_INDEX_WIDTH = 2;

   // Debounce run counters saturate here; a falling edge is a low run of EDGE_RUN.
   localparam logic [RUN_WIDTH-1:0] RUN_MAX  = 8'd250;
   localparam logic [RUN_WIDTH-1:0] EDGE_RUN = 8'd9;
   localparam logic [EDGES_WIDTH-1:0] EDGES_MAX = 8'd255;

   // Blink masks on the tick phase for each mode.
   localparam logic [PHASE_WIDTH-1:0] BLINK_MASK_IDLE   = 7'h7F;
   localparam logic [PHASE_WIDTH-1:0] BLINK_MASK_ACTIVE = 7'h0F;
   localparam logic [PHASE_WIDTH-1:0] BLINK_MASK_REBOOT = 7'h03;

   // Register reset values.
   localparam logic [TICKS_WIDTH-1:0] TIMEOUT_RESET  = 16'd6000;
   localparam logic [TICKS_WIDTH-1:0] RECOVERY_RESET = 16'd1000;
   localparam logic [EDGES_WIDTH-1:0] ARM_EDGES_RESET = 8'd3;

   // Register indexes on the configuration port.
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TIMEOUT_TICKS  = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_RECOVERY_TICKS = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ARM_EDGE_COUNT = 2'd2;

   // Mode codes as reported on the result channel.
   localparam logic [1:0] WATCH_IDLE   = 2'd0;
   localparam logic [1:0] WATCH_ACTIVE = 2'd1;
   localparam logic [1:0] WATCH_REBOOT = 2'd2;

   typedef enum logic [2:0] {
      MODE_IDLE   = 3'b001,
      MODE_ACTIVE = 3'b010,
      MODE_REBOOT = 3'b100
   } mode_type;

   typedef struct packed {
      logic [TICKS_WIDTH-1:0] timeout_ticks;
      logic [TICKS_WIDTH-1:0] recovery_ticks;
      logic [EDGES_WIDTH-1:0] arm_edge_count;
   } cfg_type;

   typedef struct packed {
      logic       edge_seen;
      logic [1:0] watch_mode;
      logic       led_level;
      logic       power_enable;
   } result_type;

endpackage

FILE: rtl/hwpc_debounce.sv
// Heartbeat debounce: saturating low and high run counters and falling edge detection.
module hwpc_debounce (
   input  logic clock,
   input  logic reset,
   input  logic step_en,
   input  logic pin_level,
   output logic edge_seen
);
   import hwpc_pkg::*;

   logic [RUN_WIDTH-1:0] low_run_ff, low_run_in;
   logic [RUN_WIDTH-1:0] high_run_ff, high_run_in;

   always_comb begin
      low_run_in  = low_run_ff;
      high_run_in = high_run_ff;
      if (!pin_level) begin
         high_run_in = '0;
         if (low_run_ff < RUN_MAX) begin
            low_run_in = low_run_ff + RUN_WIDTH'(1);
         end
      end else begin
         low_run_in = '0;
         if (high_run_ff < RUN_MAX) begin
            high_run_in = high_run_ff + RUN_WIDTH'(1);
         end
      end
   end

   // The edge is reported on the tick at which the low run reaches its mark.
   assign edge_seen = (low_run_in == EDGE_RUN);

   always_ff @(posedge clock) begin
      if (reset) begin
         low_run_ff  <= '0;
         high_run_ff <= '0;
      end else if (step_en) begin
         low_run_ff  <= low_run_in;
         high_run_ff <= high_run_in;
      end
   end

endmodule

FILE: rtl/hwpc_core.sv
// Mode sequencer, timeout and recovery timing, arming and LED blink of the watchdog.
module hwpc_core #(
   parameter int TIMER_WIDTH = hwpc_pkg::TIMER_WIDTH_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step_en,
   input  logic                 jumper_open,
   input  logic                 edge_seen,
   input  hwpc_pkg::cfg_type    cfg,
   output hwpc_pkg::result_type result
);
   import hwpc_pkg::*;

   localparam int CMP_WIDTH = (TIMER_WIDTH > TICKS_WIDTH) ? TIMER_WIDTH : TICKS_WIDTH;
   localparam logic [TIMER_WIDTH-1:0] TIMER_MAX = {TIMER_WIDTH{1'b1}};

   mode_type                mode_ff, mode_in;
   logic [PHASE_WIDTH-1:0]  phase_ff, phase_in;
   logic [TIMER_WIDTH-1:0]  elapsed_ff, elapsed_in;
   logic [TIMER_WIDTH-1:0]  elapsed_inc;
   logic [EDGES_WIDTH-1:0]  arm_edges_ff, arm_edges_in;
   logic                    power_ff, power_in;
   logic                    led_ff, led_in;
   logic                    blink;
   logic [CMP_WIDTH-1:0]    elapsed_cmp;
   logic [1:0]              watch_mode;

   assign phase_in    = phase_ff + PHASE_WIDTH'(1);
   assign elapsed_inc = (elapsed_ff < TIMER_MAX) ? elapsed_ff + TIMER_WIDTH'(1) : elapsed_ff;
   assign elapsed_cmp = CMP_WIDTH'(elapsed_inc);

   always_comb begin
      mode_in      = mode_ff;
      elapsed_in   = elapsed_inc;
      arm_edges_in = arm_edges_ff;
      power_in     = power_ff;
      blink        = 1'b0;
      case (mode_ff)
         MODE_REBOOT: begin
            blink        = ((phase_in & BLINK_MASK_REBOOT) == '0);
            power_in     = 1'b0;
            arm_edges_in = '0;
            if (elapsed_cmp >= CMP_WIDTH'(cfg.recovery_ticks)) begin
               mode_in    = MODE_IDLE;
               elapsed_in = '0;
            end
         end
         MODE_IDLE: begin
            blink      = ((phase_in & BLINK_MASK_IDLE) == '0);
            power_in   = 1'b1;
            elapsed_in = '0;
            if (edge_seen) begin
               if (arm_edges_ff < EDGES_MAX) begin
                  arm_edges_in = arm_edges_ff + EDGES_WIDTH'(1);
               end
               if (arm_edges_in > cfg.arm_edge_count) begin
                  mode_in = MODE_ACTIVE;
               end
            end
         end
         MODE_ACTIVE: begin
            blink    = ((phase_in & BLINK_MASK_ACTIVE) == '0);
            power_in = 1'b1;
            if (edge_seen) begin
               elapsed_in = '0;
            end
            if (CMP_WIDTH'(elapsed_in) >= CMP_WIDTH'(cfg.timeout_ticks)) begin
               mode_in    = MODE_REBOOT;
               elapsed_in = '0;
            end
         end
         default: begin
            // A corrupted mode forces a reboot; power is left alone and the LED does not blink.
            mode_in    = MODE_REBOOT;
            elapsed_in = '0;
         end
      endcase

      if (jumper_open) begin
         led_in = 1'b0;
      end else begin
         led_in = led_ff ^ blink;
      end
   end

   always_comb begin
      case (mode_in)
         MODE_IDLE:   watch_mode = WATCH_IDLE;
         MODE_ACTIVE: watch_mode = WATCH_ACTIVE;
         MODE_REBOOT: watch_mode = WATCH_REBOOT;
         default:     watch_mode = WATCH_REBOOT;
      endcase
   end

   assign result.power_enable = power_in;
   assign result.led_level    = led_in;
   assign result.watch_mode   = watch_mode;
   assign result.edge_seen    = edge_seen;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_IDLE;
         phase_ff     <= '0;
         elapsed_ff   <= '0;
         arm_edges_ff <= '0;
         power_ff     <= 1'b1;
         led_ff       <= 1'b0;
      end else if (step_en) begin
         mode_ff      <= mode_in;
         phase_ff     <= phase_in;
         elapsed_ff   <= elapsed_in;
         arm_edges_ff <= arm_edges_in;
         power_ff     <= power_in;
         led_ff       <= led_in;
      end
   end

endmodule

FILE: rtl/heartbeat_watchdog_power_cycler.sv
// Top level of the heartbeat watchdog power cycler: ports, registers and item pipeline.
//
// Each item on the req channel is one timer tick carrying the raw heartbeat pin and the
// LED jumper pin; for every item exactly one result leaves on the rsp channel, giving the
// supply switch drive, the status LED level, the mode after the tick and whether a
// debounced falling edge of the heartbeat was seen on that tick. The heartbeat is
// debounced by run counters that saturate at 250, and an edge is a low run of exactly
// nine ticks. In idle the target stays powered and the block arms once more than
// arm_edge_count edges have been counted; in active every edge restarts the timeout and a
// timeout of timeout_ticks starts a reboot; in reboot the power is held off for
// recovery_ticks and the block then returns to idle. The LED blinks every 128, 16 or 4
// ticks in idle, active and reboot, and is held off while the jumper is open. An item
// sits in an input register, the tick logic runs between that register and the result
// register, and one item is accepted in every clock cycle; the only limit on the rate is
// the result register being taken. The configuration registers are always ready and are
// meant to be written while no item is in flight. There is no clearing pass after reset.
module heartbeat_watchdog_power_cycler #(
   parameter int TIMER_WIDTH = hwpc_pkg::TIMER_WIDTH_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // Input items
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [7:0]                           req_tdata,  // [0] pulse_pin_level,
                                                            // [1] jumper_pin_level, [7:2] zero
   // Result items
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [7:0]                           rsp_tdata,  // [0] power_enable, [1] led_level,
                                                            // [3:2] watch_mode, [4] edge_seen,
                                                            // [7:5] zero
   // Register writes
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [hwpc_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [hwpc_pkg::TICKS_WIDTH-1:0]     csr_wdata
);
   import hwpc_pkg::*;

   cfg_type    cfg_ff, cfg_in;

   logic       in_valid_ff, in_valid_in;
   logic       in_pulse_ff;
   logic       in_jumper_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_data_ff;
   result_type step_result;
   logic       advance;
   logic       req_take;
   logic       edge_seen;

   // Register writes: the edge count keeps only the low byte of the data; index three is ignored.
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_TIMEOUT_TICKS:  cfg_in.timeout_ticks  = csr_wdata;
            CSR_RECOVERY_TICKS: cfg_in.recovery_ticks = csr_wdata;
            CSR_ARM_EDGE_COUNT: cfg_in.arm_edge_count = csr_wdata[EDGES_WIDTH-1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.timeout_ticks  <= TIMEOUT_RESET;
         cfg_ff.recovery_ticks <= RECOVERY_RESET;
         cfg_ff.arm_edge_count <= ARM_EDGES_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // The tick in the input register is processed when the result register is free or
   // is being emptied in the same cycle.
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   assign in_valid_in  = req_tready ? req_tvalid : in_valid_ff;
   assign rsp_valid_in = advance ? 1'b1 : (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_pulse_ff  <= req_tdata[0];
         in_jumper_ff <= req_tdata[1];
      end
      if (advance) begin
         rsp_data_ff <= step_result;
      end
   end

   hwpc_debounce u_debounce (
      .clock     (clock),
      .reset     (reset),
      .step_en   (advance),
      .pin_level (in_pulse_ff),
      .edge_seen (edge_seen)
   );

   hwpc_core #(
      .TIMER_WIDTH (TIMER_WIDTH)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .step_en     (advance),
      .jumper_open (in_jumper_ff),
      .edge_seen   (edge_seen),
      .cfg         (cfg_ff),
      .result      (step_result)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_data_ff};

endmodule

FILE: verif/tb.sv
// Self-checking testbench for the heartbeat watchdog power cycler.
`timescale 1ns / 100ps

module tb;
   import hwpc_pkg::*;

   // The unused fourth register index; writes to it must change nothing.
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UNUSED = 2'd3;

   // Tracks the expected watchdog behaviour tick by tick. It holds its own copy of the
   // registers and of the debounce, timer and mode state. It queues one expected result
   // for every accepted tick and retires that result when the block produces it.
   class watchdog_tracker;
      logic [TICKS_WIDTH-1:0]         timeout_ticks;
      logic [TICKS_WIDTH-1:0]         recovery_ticks;
      logic [EDGES_WIDTH-1:0]         arm_edge_count;
      logic [1:0]                     mode;
      logic [RUN_WIDTH-1:0]           low_run;
      logic [RUN_WIDTH-1:0]           high_run;
      logic [PHASE_WIDTH-1:0]         phase;
      logic [TIMER_WIDTH_DEFAULT-1:0] elapsed;
      logic [EDGES_WIDTH-1:0]         arm_edges;
      logic                           power_on;
      logic                           led_on;
      result_type                     pending_results[$];
      int                             errors;
      int                             checked;
      int                             edges;
      int                             arms;
      int                             reboots;

      function new();
         timeout_ticks  = TIMEOUT_RESET;
         recovery_ticks = RECOVERY_RESET;
         arm_edge_count = ARM_EDGES_RESET;
         mode           = WATCH_IDLE;
         low_run        = '0;
         high_run       = '0;
         phase          = '0;
         elapsed        = '0;
         arm_edges      = '0;
         power_on       = 1'b1;
         led_on         = 1'b0;
         errors         = 0;
         checked        = 0;
         edges          = 0;
         arms           = 0;
         reboots        = 0;
      endfunction

      function void write_register(logic [CSR_INDEX_WIDTH-1:0] index,
                                   logic [TICKS_WIDTH-1:0] value);
         case (index)
            CSR_TIMEOUT_TICKS:  timeout_ticks  = value;
            CSR_RECOVERY_TICKS: recovery_ticks = value;
            CSR_ARM_EDGE_COUNT: arm_edge_count = value[EDGES_WIDTH-1:0];
            default: ;
         endcase
      endfunction

      function void note_tick(logic pin_high, logic jumper_open);
         logic       edge_now;
         logic       blink;
         result_type want;
         blink = 1'b0;
         // Debounce: the run counters saturate, and an edge is a low run of exactly nine.
         if (!pin_high) begin
            high_run = '0;
            if (low_run < RUN_MAX)
               low_run++;
         end else begin
            if (high_run < RUN_MAX)
               high_run++;
            low_run = '0;
         end
         phase = phase + 1'b1;
         if (elapsed != '1)
            elapsed++;
         edge_now = (low_run == EDGE_RUN);
         if (edge_now)
            edges++;

         case (mode)
            WATCH_REBOOT: begin
               blink    = (phase & BLINK_MASK_REBOOT) == '0;
               power_on = 1'b0;
               if (elapsed >= recovery_ticks) begin
                  mode    = WATCH_IDLE;
                  elapsed = '0;
               end
               arm_edges = '0;
            end
            WATCH_IDLE: begin
               blink    = (phase & BLINK_MASK_IDLE) == '0;
               power_on = 1'b1;
               elapsed  = '0;
               if (edge_now) begin
                  if (arm_edges < EDGES_MAX)
                     arm_edges++;
                  if (arm_edges > arm_edge_count) begin
                     mode = WATCH_ACTIVE;
                     arms++;
                  end
               end
            end
            WATCH_ACTIVE: begin
               blink    = (phase & BLINK_MASK_ACTIVE) == '0;
               power_on = 1'b1;
               if (edge_now)
                  elapsed = '0;
               if (elapsed >= timeout_ticks) begin
                  mode    = WATCH_REBOOT;
                  elapsed = '0;
                  reboots++;
               end
            end
            default: begin
               mode    = WATCH_REBOOT;
               elapsed = '0;
            end
         endcase

         if (jumper_open)
            led_on = 1'b0;
         else if (blink)
            led_on = ~led_on;

         want.power_enable = power_on;
         want.led_level    = led_on;
         want.watch_mode   = mode;
         want.edge_seen    = edge_now;
         pending_results.push_back(want);
      endfunction

      function void check_result(logic [7:0] data);
         result_type got;
         result_type want;
         got = result_type'(data[4:0]);
         if (pending_results.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("Result with no tick outstanding: power %0b led %0b mode %0d edge %0b",
                        got.power_enable, got.led_level, got.watch_mode, got.edge_seen);
            return;
         end
         want = pending_results.pop_front();
         checked++;
         if (got.power_enable !== want.power_enable || got.led_level !== want.led_level ||
             got.watch_mode !== want.watch_mode || got.edge_seen !== want.edge_seen) begin
            errors++;
            if (errors <= 10)
               $display("Mismatch on result %0d: expected power %0b led %0b mode %0d edge %0b,",
                        checked, want.power_enable, want.led_level, want.watch_mode,
                        want.edge_seen,
                        " got power %0b led %0b mode %0d edge %0b",
                        got.power_enable, got.led_level, got.watch_mode, got.edge_seen);
         end
      endfunction
   endclass

   logic                       clock;
   logic                       reset      = 1'b1;
   logic                       req_tvalid = 1'b0;
   logic                       req_tready;
   logic [7:0]                 req_tdata  = 8'h00;
   logic                       rsp_tvalid;
   logic                       rsp_tready = 1'b0;
   logic [7:0]                 rsp_tdata;
   logic                       csr_valid  = 1'b0;
   logic                       csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index  = '0;
   logic [TICKS_WIDTH-1:0]     csr_wdata  = '0;

   watchdog_tracker tracker;

   // When clear, neither side inserts gaps, so the block runs at full rate.
   bit pacing_on = 1'b1;
   // Chance in percent that the LED jumper reads as open on a tick.
   int jumper_open_pct = 0;
   int ticks_sent = 0;

   heartbeat_watchdog_power_cycler uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // [0] pulse_pin_level, [1] jumper_pin_level, [7:2] zero
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // [0] power_enable, [1] led_level, [3:2] watch_mode,
                                 // [4] edge_seen, [7:5] zero
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Observe every handshake at the clock edge. The testbench changes its signals only
   // through nonblocking assignments, and so does the block. The values read here are
   // therefore the ones that the block sampled at the same edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready)
            tracker.write_register(csr_index, csr_wdata);
         if (req_tvalid && req_tready)
            tracker.note_tick(req_tdata[0], req_tdata[1]);
         if (rsp_tvalid && rsp_tready)
            tracker.check_result(rsp_tdata);
      end
   end

   // Result side: before each item, hold tready low for a random stall, then take the item.
   initial begin : result_sink
      int stall;
      forever begin
         stall = pacing_on ? $urandom_range(0, 8) : 0;
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
      end
   end

   // Offer one tick after a random gap and hold it until the block takes it. The valid
   // stays high on return, so the caller must either offer the next tick or lower it in
   // the same time step.
   task automatic send_tick(logic pin_high, logic jumper_open);
      int gap;
      gap = pacing_on ? $urandom_range(0, 8) : 0;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {6'b000000, jumper_open, pin_high};
      do @(posedge clock); while (!req_tready);
      ticks_sent++;
   endtask

   // Hold the heartbeat pin at one level for a number of ticks. The jumper is drawn per tick.
   task automatic send_level(logic pin_high, int count);
      repeat (count)
         send_tick(pin_high, $urandom_range(0, 99) < jumper_open_pct);
   endtask

   // Stop sending and wait until every expected result has been taken and the pipeline
   // is empty.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (tracker.pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Write all three registers once the block is idle. The unused index can optionally be
   // written as well, and that write must have no effect.
   task automatic program_registers(logic [TICKS_WIDTH-1:0] timeout_value,
                                    logic [TICKS_WIDTH-1:0] recovery_value,
                                    logic [TICKS_WIDTH-1:0] arm_value,
                                    bit poke_unused);
      logic [CSR_INDEX_WIDTH-1:0] index_list[4];
      logic [TICKS_WIDTH-1:0]     value_list[4];
      int                         writes;
      index_list[0] = CSR_TIMEOUT_TICKS;   value_list[0] = timeout_value;
      index_list[1] = CSR_RECOVERY_TICKS;  value_list[1] = recovery_value;
      index_list[2] = CSR_ARM_EDGE_COUNT;  value_list[2] = arm_value;
      index_list[3] = CSR_UNUSED;          value_list[3] = 16'h0005;
      writes = poke_unused ? 4 : 3;
      drain_results();
      for (int i = 0; i < writes; i++) begin
         csr_valid <= 1'b1;
         csr_index <= index_list[i];
         csr_wdata <= value_list[i];
         do @(posedge clock); while (!csr_ready);
      end
      csr_valid <= 1'b0;
   endtask

   // Mixed heartbeat traffic. Most of it is well-formed pulses that debounce into edges.
   // The rest is short lows that stop before an edge, raw noise, and silences of up to
   // silence_max ticks. Now and then the pacing is switched on or off.
   task automatic heartbeat_traffic(int count, int silence_max);
      int goal;
      int pick;
      goal = ticks_sent + count;
      while (ticks_sent < goal) begin
         pick = $urandom_range(0, 99);
         if (pick < 60) begin
            send_level(1'b1, $urandom_range(1, 4));
            send_level(1'b0, $urandom_range(9, 20));
         end else if (pick < 75) begin
            send_level(1'b1, $urandom_range(1, 3));
            send_level(1'b0, $urandom_range(1, 8));
         end else if (pick < 85) begin
            repeat ($urandom_range(1, 10))
               send_tick(1'($urandom_range(0, 1)), $urandom_range(0, 99) < jumper_open_pct);
         end else if (pick < 95) begin
            send_level(1'($urandom_range(0, 1)), $urandom_range(10, silence_max));
         end else begin
            pacing_on = 1'($urandom_range(0, 1));
         end
      end
   endtask

   initial begin
      tracker = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed ticks at the reset settings. A clean pulse gives an edge on the ninth low
      // tick. An open jumper forces the LED off. Short lows never produce an edge.
      jumper_open_pct = 0;
      send_level(1'b1, 2);
      send_level(1'b0, 10);
      jumper_open_pct = 100;
      send_level(1'b0, 2);
      send_level(1'b1, 1);
      jumper_open_pct = 0;
      send_level(1'b0, 5);
      send_level(1'b1, 1);
      send_level(1'b0, 3);
      jumper_open_pct = 50;
      send_level(1'b1, 1);

      // Short timeout with a low arming threshold. A write to the unused index must not
      // change anything.
      jumper_open_pct = 15;
      program_registers(16'd40, 16'd12, 16'd2, 1'b1);
      pacing_on = 1'b1;
      heartbeat_traffic(500, 60);

      // Lowest settings: a single tick times out or recovers, and a single edge arms.
      program_registers(16'd1, 16'd1, 16'd0, 1'b0);
      pacing_on = 1'b1;
      heartbeat_traffic(350, 20);

      // Long silences here can saturate the low or high run.
      program_registers(16'd300, 16'd100, 16'd5, 1'b0);
      pacing_on = 1'b1;
      heartbeat_traffic(400, 300);

      // The arming threshold is written with upper bits set, so only the low byte, two, is
      // kept. A long high stretch saturates the high run; it and ten pulses go at full rate.
      program_registers(16'd2000, 16'd50, 16'hA502, 1'b0);
      pacing_on = 1'b0;
      send_level(1'b1, 260);
      repeat (10) begin
         send_level(1'b1, 1);
         send_level(1'b0, 9);
      end
      pacing_on = 1'b1;
      repeat (3) begin
         send_level(1'b1, 2);
         send_level(1'b0, 12);
      end

      drain_results();
      $display("Covered %0d ticks: %0d edges, %0d arms, %0d reboots over five register sets.",
               ticks_sent, tracker.edges, tracker.arms, tracker.reboots);
      $display("%0d results checked, %0d mismatches.", tracker.checked, tracker.errors);
      if (tracker.errors == 0 && tracker.pending_results.size() == 0) begin
         $display("PASS heartbeat_watchdog_power_cycler");
      end else begin
         $display("FAIL heartbeat_watchdog_power_cycler");
      end
      $finish;
   end

   // Give up after several times the length of the slowest correct run.
   initial begin
      #(2_000_000);
      $display("FAIL heartbeat_watchdog_power_cycler");
      $finish;
   end

endmodule
